/* sv/mfba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfba_pkg: shared types and codes of the multi-frame bump allocator
// Status and function codes, register map and the cell control bundle.
// ----------------------------------------------------------------------------
package mfba_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned ASIZE_W  = SIZE_W + 1;  // aligned size may carry
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned TOTAL_W  = 37;
  localparam int unsigned OUT_W    = STATUS_W + FIDX_W + SIZE_W + TOTAL_W;
  localparam int unsigned OUT_DW   = ((OUT_W + 7) / 8) * 8;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_BIG  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd2;

  // Request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  // Register map (index = byte address / 4)
  localparam logic REG_FRAME_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] FRAME_SIZE_RST = 32'd65536;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic fit_en;    // evaluate fit against the current request
    logic alloc_go;  // commit an allocation to the winning cell
    logic clear_go;  // empty every open frame
  } cell_ctrl_t;

endpackage : mfba_pkg
`default_nettype wire

/* sv/mfba_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfba_cell: one frame of the allocator
// Holds the fill count and open flag of one frame, checks whether the
// request fits, and takes part in the first-fit priority chain.
// ----------------------------------------------------------------------------
module mfba_cell
  import mfba_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 4
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cell_ctrl_t             ctrl,
  input  wire  [ASIZE_W-1:0]     size,
  input  wire  [SIZE_W-1:0]      frame_size,
  input  wire                    taken_in,
  output logic                   taken_out,
  input  wire  [SIZE_W-1:0]      off_in,
  output logic [SIZE_W-1:0]      off_out,
  input  wire  [IDX_W-1:0]       idx_in,
  output logic [IDX_W-1:0]       idx_out
);

  logic              open_r;
  logic              fit_r;
  logic [SIZE_W-1:0] fill_r;
  logic [ASIZE_W:0]  sum;
  logic              cand;
  logic              win;

  // Fit check, registered ahead of the chain
  assign sum = {2'b00, fill_r} + {1'b0, size};

  always_ff @(posedge clk) begin
    if (ctrl.fit_en) begin
      fit_r <= (sum <= {2'b00, frame_size});
    end
  end

  // Open frames form a prefix, so a closed cell is the fallback for a new frame
  assign cand      = open_r ? fit_r : 1'b1;
  assign win       = cand & ~taken_in;
  assign taken_out = taken_in | cand;
  assign off_out   = off_in | ((win && open_r) ? fill_r : '0);
  assign idx_out   = idx_in | (win ? IDX_W'(IDX) : '0);

  // Open flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (ctrl.alloc_go && win) begin
      open_r <= 1'b1;
    end
  end

  // Fill count: bump on allocation, zero on reset request
  always_ff @(posedge clk) begin
    if (ctrl.alloc_go && win) begin
      fill_r <= open_r ? (fill_r + size[SIZE_W-1:0]) : size[SIZE_W-1:0];
    end else if (ctrl.clear_go && open_r) begin
      fill_r <= '0;
    end
  end

endmodule : mfba_cell
`default_nettype wire

/* sv/multi_frame_bump_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_frame_bump_allocator: first-fit bump allocator over equal frames
// Usage: each input transaction carries a function in in_tuser (allocate or
// reset) and a byte count in in_tdata. The size is rounded up to ALIGN, the
// first open frame with room takes the block (or a new frame is opened),
// and one result transaction returns status, frame index, offset and total.
// A reset request empties all open frames and the total; frames stay open.
// Sequencing: an accepted transaction passes through the FIT state, in which
// a row of frame cells registers its fit checks, and then the COMMIT state,
// in which the first-fit priority chain resolves and the updates are made. A
// new transaction is accepted as the previous one commits.
// The result sits in an output register; while the receiver stalls the next
// transaction is still accepted and evaluated, and its commit waits until the
// held result is taken.
// Reset (rst_n low, synchronous) closes all frames, clears the total, sets
// frame_size to 65536 and empties the output register.
// frame_size lies at byte address 0 of the APB port; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module multi_frame_bump_allocator
  import mfba_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned ALIGN      = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  // input request channel
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [31:0]       in_tdata,   // [31:0] request_size
  input  wire               in_tuser,   // [0] func
  // result channel
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [1:0] status, [5:2] frame_index,
                                        // [37:6] block_offset, [74:38] total_used
  // configuration port
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire  [2:0]        cfg_paddr,
  input  wire  [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [ASIZE_W-1:0] ALIGN_M = ASIZE_W'(ALIGN - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_FIT    = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   frame_size_r;
  logic                func_r;
  logic [ASIZE_W-1:0]  size_r;
  logic                too_big_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                out_valid_r;
  logic [OUT_DW-1:0]   out_data_r;
  logic [OUT_DW-1:0]   out_data_nxt;
  logic                in_acc;
  logic                commit_ok;
  logic                commit;
  logic [ASIZE_W-1:0]  size_aligned;
  cell_ctrl_t          ctrl;

  logic [MAX_FRAMES:0]             taken;
  logic [MAX_FRAMES:0][SIZE_W-1:0] off;
  logic [MAX_FRAMES:0][IDX_W-1:0]  idx;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAME_SIZE) ? frame_size_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_FRAME_SIZE)) begin
      frame_size_r <= cfg_pwdata;
    end
  end

  // Handshake and sequencing
  assign commit_ok = ~out_valid_r | out_tready;
  assign commit    = (state_r == ST_COMMIT) && commit_ok;
  assign in_tready = (state_r == ST_IDLE) || commit;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_FIT;
      ST_FIT:    state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (commit) state_nxt = in_acc ? ST_FIT : ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request capture with alignment rounding
  assign size_aligned = ({1'b0, in_tdata} + ALIGN_M) & ~ALIGN_M;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_tuser;
      size_r <= size_aligned;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIT) begin
      too_big_r <= (size_r > {1'b0, frame_size_r});
    end
  end

  // Cell controls
  assign ctrl.fit_en   = (state_r == ST_FIT);
  assign ctrl.alloc_go = commit && (func_r == FUNC_ALLOC) && !too_big_r;
  assign ctrl.clear_go = commit && (func_r == FUNC_RESET);

  // Row of frame cells
  assign taken[0] = 1'b0;
  assign off[0]   = '0;
  assign idx[0]   = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    mfba_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .size       (size_r),
      .frame_size (frame_size_r),
      .taken_in   (taken[g]),
      .taken_out  (taken[g+1]),
      .off_in     (off[g]),
      .off_out    (off[g+1]),
      .idx_in     (idx[g]),
      .idx_out    (idx[g+1])
    );
  end

  // Running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctrl.clear_go) begin
      total_r <= '0;
    end else if (ctrl.alloc_go && taken[MAX_FRAMES]) begin
      total_r <= total_r + TOTAL_W'(size_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result word for the transaction being committed
  always_comb begin
    out_data_nxt = '0;
    if (func_r == FUNC_RESET) begin
      out_data_nxt[STATUS_W-1:0] = STATUS_OK;
    end else if (too_big_r) begin
      out_data_nxt[STATUS_W-1:0]       = STATUS_TOO_BIG;
      out_data_nxt[OUT_W-1 -: TOTAL_W] = total_r;
    end else if (!taken[MAX_FRAMES]) begin
      out_data_nxt[STATUS_W-1:0]       = STATUS_NO_FRAME;
      out_data_nxt[OUT_W-1 -: TOTAL_W] = total_r;
    end else begin
      out_data_nxt[STATUS_W-1:0]                = STATUS_OK;
      out_data_nxt[STATUS_W +: FIDX_W]          = FIDX_W'(idx[MAX_FRAMES]);
      out_data_nxt[STATUS_W + FIDX_W +: SIZE_W] = off[MAX_FRAMES];
      out_data_nxt[OUT_W-1 -: TOTAL_W]          = total_r + TOTAL_W'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : multi_frame_bump_allocator
`default_nettype wire

/* tb/sv/multi_frame_bump_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_frame_bump_allocator_tb: self-checking bench for the frame allocator
// Sends allocate and reset requests over the input stream. A behavioral
// first-fit model with its own frame fill table predicts every answer.
// Each result transaction is checked field by field, in order. The bench
// steps frame_size through its extremes over the APB port while the block
// is idle. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module multi_frame_bump_allocator_tb;
  import mfba_pkg::*;

  localparam int MAX_FRAMES      = 16;
  localparam int ALIGN           = 16;
  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 6;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int REG_STRIDE      = 4;
  localparam int REG_UNMAPPED    = 1;
  localparam int RANDOM_ROUNDS   = 8;
  localparam int ITEMS_PER_ROUND = 232;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   frame_index;
    logic [SIZE_W-1:0]   block_offset;
    logic [TOTAL_W-1:0]  total_used;
  } alloc_answer_t;

  // DUT connections
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata    = '0;   // [31:0] request_size
  logic              in_tuser    = 1'b0; // [0] func
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_DW-1:0] out_tdata;          // [1:0] status, [5:2] frame_index,
                                         // [37:6] block_offset, [74:38] total_used
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [2:0]        cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Allocator state as the bench sees it
  logic [SIZE_W-1:0]  frame_fill [MAX_FRAMES];
  int                 frames_open;
  logic [TOTAL_W-1:0] running_total;
  logic [SIZE_W-1:0]  frame_size_cfg;

  alloc_answer_t alloc_answers_q [$];
  int            mismatch_count = 0;
  int            results_seen   = 0;
  int            cycle_count    = 0;
  int            send_gap_pct   = 0;
  int            stall_pct      = 0;

  multi_frame_bump_allocator #(
    .MAX_FRAMES (MAX_FRAMES),
    .ALIGN      (ALIGN)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    $display("[%0t] result %0d %s: expected 0x%0h, got 0x%0h",
             $time, results_seen, what, want, got);
  endtask

  // First-fit placement: returns the answer and advances the frame table
  function automatic alloc_answer_t predict_allocation(input logic func,
                                                       input logic [31:0] req);
    alloc_answer_t ans;
    logic [32:0]   aligned;
    int            pick;
    ans  = '0;
    pick = -1;
    if (func == FUNC_RESET) begin
      for (int i = 0; i < frames_open; i++) frame_fill[i] = '0;
      running_total = '0;
      return ans;
    end
    aligned = ({1'b0, req} + 33'(ALIGN - 1)) & ~33'(ALIGN - 1);
    if (aligned > {1'b0, frame_size_cfg}) begin
      ans.status     = STATUS_TOO_BIG;
      ans.total_used = running_total;
      return ans;
    end
    // over-full frames (after a shrink) never match
    for (int i = 0; i < frames_open; i++) begin
      if (pick < 0 && {2'b0, frame_fill[i]} + {1'b0, aligned} <= {2'b0, frame_size_cfg})
        pick = i;
    end
    if (pick < 0 && frames_open < MAX_FRAMES) begin
      pick             = frames_open;
      frame_fill[pick] = '0;
      frames_open++;
    end
    if (pick < 0) begin
      ans.status     = STATUS_NO_FRAME;
      ans.total_used = running_total;
      return ans;
    end
    ans.status       = STATUS_OK;
    ans.frame_index  = pick[FIDX_W-1:0];
    ans.block_offset = frame_fill[pick];
    frame_fill[pick] = frame_fill[pick] + aligned[31:0];
    running_total    = running_total + TOTAL_W'(aligned);
    ans.total_used   = running_total;
    return ans;
  endfunction

  // Result checker
  always @(posedge clk) begin
    alloc_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (alloc_answers_q.size() == 0) begin
        report_mismatch("arrived with nothing pending", '0, out_tdata[63:0]);
      end else begin
        want = alloc_answers_q.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", want.status, out_tdata[1:0]);
        if (out_tdata[5:2] !== want.frame_index)
          report_mismatch("frame_index", want.frame_index, out_tdata[5:2]);
        if (out_tdata[37:6] !== want.block_offset)
          report_mismatch("block_offset", want.block_offset, out_tdata[37:6]);
        if (out_tdata[74:38] !== want.total_used)
          report_mismatch("total_used", want.total_used, out_tdata[74:38]);
      end
    end
  end

  task automatic set_idling(input idle_phase_t phase);
    case (phase)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 81;
        stall_pct    = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 81;
      end
      default: begin
        send_gap_pct = 31;
        stall_pct    = 31;
      end
    endcase
  endtask

  // One request transaction; tvalid stays high for a back-to-back follower
  task automatic send_request(input logic func, input logic [31:0] req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
    alloc_answers_q.push_back(predict_allocation(func, req));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (alloc_answers_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write once idle, then read frame_size back
  task automatic cfg_write(input int reg_idx, input logic [31:0] value);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(reg_idx * REG_STRIDE);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == REG_FRAME_SIZE) frame_size_cfg = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 3'(REG_FRAME_SIZE * REG_STRIDE);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== frame_size_cfg)
      report_mismatch("frame_size readback", frame_size_cfg, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_request_size(input logic [31:0] fs);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return $urandom;
    if (roll < 14) return '0;
    if (roll < 20) return fs;
    if (roll < 25) return fs + 32'd1;
    if (roll < 30) return $urandom_range(ALIGN);
    return $urandom_range(0, fs / 4 + ALIGN);
  endfunction

  // Default frame size: rounding, exact fit, oversize and reset request
  task automatic test_basic_placement();
    set_idling(IDLE_NONE);
    send_request(FUNC_ALLOC, 32'd0);
    send_request(FUNC_ALLOC, 32'd1);
    send_request(FUNC_ALLOC, 32'd17);
    send_request(FUNC_ALLOC, 32'd65536);
    send_request(FUNC_ALLOC, 32'd65537);
    send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
    send_request(FUNC_RESET, $urandom);
    send_request(FUNC_ALLOC, 32'd0);
  endtask

  // Frames filled past a lowered frame_size get skipped
  task automatic test_frame_shrink();
    cfg_write(REG_FRAME_SIZE, 32'd64);
    send_request(FUNC_ALLOC, 32'd48);
    send_request(FUNC_ALLOC, 32'd48);
    cfg_write(REG_FRAME_SIZE, 32'd32);
    send_request(FUNC_ALLOC, 32'd0);
    send_request(FUNC_ALLOC, 32'd32);
  endtask

  // Only empty requests fit a zero-size frame
  task automatic test_zero_frame_size();
    cfg_write(REG_FRAME_SIZE, 32'd0);
    send_request(FUNC_ALLOC, 32'd0);
    send_request(FUNC_ALLOC, 32'd1);
    send_request(FUNC_RESET, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 32'd0);
  endtask

  // Full 32-bit frame, carry out of rounding, unmapped register write
  task automatic test_widest_frame();
    cfg_write(REG_FRAME_SIZE, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 32'hFFFF_FFF0);
    send_request(FUNC_ALLOC, 32'hFFFF_FFF1);
    send_request(FUNC_ALLOC, 32'd16);
    cfg_write(REG_UNMAPPED, 32'd64);
    send_request(FUNC_ALLOC, 32'hFFFF_FFF0);
  endtask

  // Mostly fitting allocations with sparse resets, plus out-of-range sizes
  task automatic test_random_traffic();
    logic [31:0] fs;
    logic        func;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      case (round)
        0:       fs = 32'd64;
        1:       fs = 32'd256;
        2:       fs = 32'd0;
        3:       fs = 32'hFFFF_FFFF;
        4:       fs = $urandom_range(16, 4096);
        5:       fs = 32'd1;
        6:       fs = $urandom;
        default: fs = FRAME_SIZE_RST;
      endcase
      cfg_write(REG_FRAME_SIZE, fs);
      set_idling(idle_phase_t'(round % 4));
      for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
        func = ($urandom_range(99) < 2) ? FUNC_RESET : FUNC_ALLOC;
        send_request(func, (func == FUNC_RESET) ? $urandom : pick_request_size(fs));
      end
    end
  endtask

  initial begin
    frame_size_cfg = FRAME_SIZE_RST;
    frames_open    = 0;
    running_total  = '0;
    set_idling(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_placement();
    test_frame_shrink();
    test_zero_frame_size();
    test_widest_frame();
    test_random_traffic();

    drain_results();
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mfba_pkg.sv
sv/mfba_cell.sv
sv/multi_frame_bump_allocator.sv
tb/sv/multi_frame_bump_allocator_tb.sv
